// File: rtl/rgb_box_blur_3x3_top_defines.svh
// Assertion macros used by the box blur pixel stage.
`ifndef RGB_BOX_BLUR_3X3_TOP_DEFINES_SVH
`define RGB_BOX_BLUR_3X3_TOP_DEFINES_SVH

`ifndef SYNTH
`define BB3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bb3 same-cycle check failed");
`define BB3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bb3 next-cycle check failed");
`else
`define BB3_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BB3_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: rtl/bb3_pkg.sv
// Shared types, constants and the reciprocal table of the box blur.
package bb3_pkg;

    localparam int PIX_W       = 8;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int POS_W       = 10;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RCP_W       = 16;
    localparam int RCP_SHIFT   = 16;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int DIM_RESET   = 1024;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // result slots of one input pixel, in release order
    localparam int SLOT_UL   = 0;   // row-1, col-1
    localparam int SLOT_UR   = 1;   // row-1, col (last column)
    localparam int SLOT_LL   = 2;   // row, col-1 (last row)
    localparam int SLOT_LR   = 3;   // row, col (last pixel)
    localparam int NUM_SLOTS = 4;

    typedef logic [RGB_W-1:0] rgb_t;

    typedef struct packed {
        logic ir_ge1;
        logic ir_ge2;
        logic ic_ge1;
        logic ic_ge2;
        logic last_row;
        logic last_col;
    } pos_flags_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [CNT_W-1:0] count;
        logic             done;
    } sum_item_t;

    // ceil(2^16 / (2*count)); exact floor for numerators below 8192
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RCP_W-1:0] r;
        unique case (count)
            CNT_W'(1): r = RCP_W'(32768);
            CNT_W'(2): r = RCP_W'(16384);
            CNT_W'(3): r = RCP_W'(10923);
            CNT_W'(4): r = RCP_W'(8192);
            CNT_W'(6): r = RCP_W'(5462);
            CNT_W'(9): r = RCP_W'(3641);
            default:   r = RCP_W'(0);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bb3_line_mem.sv
// Two-row line store: one synchronous RAM with a registered read port.
module bb3_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read-before-write; the caller forwards same-address collisions
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bb3_window.sv
// Pixel stage: window columns, store read-modify-write and result sequencing.
`include "rgb_box_blur_3x3_top_defines.svh"

module bb3_window #(
    parameter int ROW_W = 10,
    parameter int COL_W = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  bb3_pkg::rgb_t            in_pix,
    input  logic [ROW_W-1:0]         in_row,
    input  logic [COL_W-1:0]         in_col,
    input  bb3_pkg::pos_flags_t      in_flags,
    output logic                     free,
    output logic                     mem_rd_en,
    output logic [COL_W-1:0]         mem_rd_addr,
    input  logic [2*bb3_pkg::RGB_W-1:0] mem_rd_data,
    output logic                     mem_wr_en,
    output logic [COL_W-1:0]         mem_wr_addr,
    output logic [2*bb3_pkg::RGB_W-1:0] mem_wr_data,
    output logic                     sum_valid,
    output bb3_pkg::sum_item_t       sum_item,
    input  logic                     sum_ready
);

    localparam int PW = bb3_pkg::PIX_W;
    localparam int RW = bb3_pkg::RGB_W;
    localparam int NS = bb3_pkg::NUM_SLOTS;

    logic                        s1_valid_reg;
    logic [NS-1:0]               s1_pend_reg;
    bb3_pkg::rgb_t               s1_pix_reg;
    logic [ROW_W-1:0]            s1_row_reg;
    logic [COL_W-1:0]            s1_col_reg;
    bb3_pkg::pos_flags_t         s1_flags_reg;
    logic                        fwd_hit_reg;
    logic [2*RW-1:0]             fwd_data_reg;
    bb3_pkg::rgb_t               win0_reg [3];
    bb3_pkg::rgb_t               win1_reg [3];
    logic                        s2_valid_reg;
    bb3_pkg::sum_item_t          s2_item_reg;

    logic [2*RW-1:0]             line_q;
    bb3_pkg::rgb_t               col2 [3];
    logic [NS-1:0]               sel;
    logic [NS-1:0]               pend_next;
    logic                        s2_ready;
    logic                        emit;
    logic                        retire;
    logic                        upper;
    logic                        left;
    logic [2:0]                  rmask;
    logic [2:0]                  cmask;
    logic [1:0]                  rows_n;
    logic [1:0]                  cols_n;
    logic [ROW_W-1:0]            orow;
    logic [COL_W-1:0]            ocol;
    logic [ROW_W+bb3_pkg::POS_W-1:0] orow_wide;
    logic [COL_W+bb3_pkg::POS_W-1:0] ocol_wide;
    bb3_pkg::sum_item_t          item_next;

    // store word: older row in the upper half, newer row in the lower half
    assign line_q  = fwd_hit_reg ? fwd_data_reg : mem_rd_data;
    assign col2[0] = line_q[2*RW-1:RW];
    assign col2[1] = line_q[RW-1:0];
    assign col2[2] = s1_pix_reg;

    always_comb
    begin
        sel = '0;
        priority if (s1_pend_reg[bb3_pkg::SLOT_UL]) sel[bb3_pkg::SLOT_UL] = 1'b1;
        else if (s1_pend_reg[bb3_pkg::SLOT_UR])     sel[bb3_pkg::SLOT_UR] = 1'b1;
        else if (s1_pend_reg[bb3_pkg::SLOT_LL])     sel[bb3_pkg::SLOT_LL] = 1'b1;
        else if (s1_pend_reg[bb3_pkg::SLOT_LR])     sel[bb3_pkg::SLOT_LR] = 1'b1;
        else                                        sel = '0;
    end

    assign s2_ready  = !s2_valid_reg || sum_ready;
    assign emit      = s1_valid_reg && (s1_pend_reg != '0) && s2_ready;
    assign pend_next = emit ? (s1_pend_reg & ~sel) : s1_pend_reg;
    assign retire    = s1_valid_reg && (pend_next == '0);
    assign free      = !s1_valid_reg || retire;

    assign mem_rd_en   = acc;
    assign mem_rd_addr = in_col;
    assign mem_wr_en   = retire;
    assign mem_wr_addr = s1_col_reg;
    assign mem_wr_data = {col2[1], s1_pix_reg};

    // in-bounds rows/cols of the grid for the selected result
    assign upper    = sel[bb3_pkg::SLOT_UL] | sel[bb3_pkg::SLOT_UR];
    assign left     = sel[bb3_pkg::SLOT_UL] | sel[bb3_pkg::SLOT_LL];
    assign rmask[0] = upper & s1_flags_reg.ir_ge2;
    assign rmask[1] = upper | s1_flags_reg.ir_ge1;
    assign rmask[2] = 1'b1;
    assign cmask[0] = left & s1_flags_reg.ic_ge2;
    assign cmask[1] = left | s1_flags_reg.ic_ge1;
    assign cmask[2] = 1'b1;
    assign rows_n   = {1'b0, rmask[0]} + {1'b0, rmask[1]} + 2'd1;
    assign cols_n   = {1'b0, cmask[0]} + {1'b0, cmask[1]} + 2'd1;

    assign orow      = upper ? (s1_row_reg - ROW_W'(1)) : s1_row_reg;
    assign ocol      = left ? (s1_col_reg - COL_W'(1)) : s1_col_reg;
    assign orow_wide = {{bb3_pkg::POS_W{1'b0}}, orow};
    assign ocol_wide = {{bb3_pkg::POS_W{1'b0}}, ocol};

    always_comb
    begin
        bb3_pkg::rgb_t px;
        item_next       = '0;
        item_next.row   = orow_wide[bb3_pkg::POS_W-1:0];
        item_next.col   = ocol_wide[bb3_pkg::POS_W-1:0];
        item_next.count = {2'b00, rows_n} * {2'b00, cols_n};
        item_next.done  = sel[bb3_pkg::SLOT_LR];
        for (int s = 0; s < 3; s++)
        begin
            for (int t = 0; t < 3; t++)
            begin
                px = (t == 0) ? win1_reg[s] : ((t == 1) ? win0_reg[s] : col2[s]);
                if (rmask[s] && cmask[t])
                begin
                    item_next.sum_r = item_next.sum_r
                        + {{(bb3_pkg::SUM_W-PW){1'b0}}, px[3*PW-1:2*PW]};
                    item_next.sum_g = item_next.sum_g
                        + {{(bb3_pkg::SUM_W-PW){1'b0}}, px[2*PW-1:PW]};
                    item_next.sum_b = item_next.sum_b
                        + {{(bb3_pkg::SUM_W-PW){1'b0}}, px[PW-1:0]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
            fwd_hit_reg  <= 1'b0;
            for (int s = 0; s < 3; s++)
            begin
                win0_reg[s] <= '0;
                win1_reg[s] <= '0;
            end
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
                s1_pend_reg  <= {in_flags.last_row & in_flags.last_col,
                                 in_flags.last_row & in_flags.ic_ge1,
                                 in_flags.ir_ge1 & in_flags.last_col,
                                 in_flags.ir_ge1 & in_flags.ic_ge1};
                fwd_hit_reg  <= retire && (s1_col_reg == in_col);
            end
            else
            begin
                s1_valid_reg <= s1_valid_reg && !retire;
                s1_pend_reg  <= pend_next;
            end
            if (retire)
            begin
                for (int s = 0; s < 3; s++)
                begin
                    win1_reg[s] <= win0_reg[s];
                    win0_reg[s] <= col2[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg   <= in_pix;
            s1_row_reg   <= in_row;
            s1_col_reg   <= in_col;
            s1_flags_reg <= in_flags;
            fwd_data_reg <= mem_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (sum_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s2_item_reg <= item_next;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum_item  = s2_item_reg;

    `BB3_ASSERT_NXT(a_acc_loads_stage, clk, rst_n, acc, s1_valid_reg)
    `BB3_ASSERT_IMP(a_multi_result_blocks, clk, rst_n,
        s1_valid_reg && ($countones(s1_pend_reg) > 1), !free)
    `BB3_ASSERT_NXT(a_count_legal, clk, rst_n, emit,
        s2_item_reg.count == 1 || s2_item_reg.count == 2 || s2_item_reg.count == 3 ||
        s2_item_reg.count == 4 || s2_item_reg.count == 6 || s2_item_reg.count == 9)

endmodule

// File: rtl/bb3_divide.sv
// Rounded mean by reciprocal multiply, into the output register.
module bb3_divide (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sum_valid,
    input  bb3_pkg::sum_item_t            sum_item,
    output logic                          sum_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bb3_pkg::POS_W-1:0]     out_row,
    output logic [bb3_pkg::POS_W-1:0]     out_col,
    output logic [bb3_pkg::PIX_W-1:0]     out_red,
    output logic [bb3_pkg::PIX_W-1:0]     out_green,
    output logic [bb3_pkg::PIX_W-1:0]     out_blue,
    output logic                          out_done
);

    localparam int NW = bb3_pkg::NUM_W;
    localparam int PRW = bb3_pkg::NUM_W + bb3_pkg::RCP_W;
    localparam int SH = bb3_pkg::RCP_SHIFT;
    localparam int PW = bb3_pkg::PIX_W;

    logic                     out_valid_reg;
    logic [bb3_pkg::POS_W-1:0] row_reg;
    logic [bb3_pkg::POS_W-1:0] col_reg;
    logic [PW-1:0]            red_reg;
    logic [PW-1:0]            green_reg;
    logic [PW-1:0]            blue_reg;
    logic                     done_reg;

    logic                     load;
    logic [bb3_pkg::RCP_W-1:0] rcp;
    logic [NW-1:0]            num_r;
    logic [NW-1:0]            num_g;
    logic [NW-1:0]            num_b;
    logic [PRW-1:0]           prod_r;
    logic [PRW-1:0]           prod_g;
    logic [PRW-1:0]           prod_b;

    assign sum_ready = !out_valid_reg || out_ready;
    assign load      = sum_valid && sum_ready;

    // floor((2*sum + n) / (2*n))
    assign rcp    = bb3_pkg::recip(sum_item.count);
    assign num_r  = {sum_item.sum_r, 1'b0} + {{(NW-bb3_pkg::CNT_W){1'b0}}, sum_item.count};
    assign num_g  = {sum_item.sum_g, 1'b0} + {{(NW-bb3_pkg::CNT_W){1'b0}}, sum_item.count};
    assign num_b  = {sum_item.sum_b, 1'b0} + {{(NW-bb3_pkg::CNT_W){1'b0}}, sum_item.count};
    assign prod_r = {{bb3_pkg::RCP_W{1'b0}}, num_r} * {{NW{1'b0}}, rcp};
    assign prod_g = {{bb3_pkg::RCP_W{1'b0}}, num_g} * {{NW{1'b0}}, rcp};
    assign prod_b = {{bb3_pkg::RCP_W{1'b0}}, num_b} * {{NW{1'b0}}, rcp};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg   <= sum_item.row;
            col_reg   <= sum_item.col;
            red_reg   <= prod_r[SH+PW-1:SH];
            green_reg <= prod_g[SH+PW-1:SH];
            blue_reg  <= prod_b[SH+PW-1:SH];
            done_reg  <= sum_item.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_done  = done_reg;

endmodule

// File: rtl/rgb_box_blur_3x3_top.sv
// Top level of the streaming 3x3 RGB box blur.
//
// Input stream s_*: one RGB pixel per item, raster order, red in the low byte.
// Output stream m_*: blurred pixels tagged with row and column; m_tlast marks
// the final pixel of the image. A result appears once its lower-right
// in-bounds neighbor has arrived, so a pixel releases zero to four results
// (four only for the last pixel of the image).
// Config port: cfg_we/cfg_index/cfg_data set width (index 0) and height
// (index 1). Values are clamped to 1..MAX. A width or height write restarts the frame at
// row 0, column 0; write only while the block is idle.
// A pixel's first result goes through the pixel stage, sum and output registers to m_tvalid.
// Throughput: 1 pixel per cycle while each pixel releases at most one result and the
// output is not stalled; a pixel releasing more holds s_tready low until all are sent.
// The line store RAM is read when a pixel is taken and written back when it
// leaves the pixel stage; a same-column overlap (width 1) is forwarded.
// Reset clears position, window and pipeline valids; dimensions reset to 1024
// (clamped to MAX). The line store needs no clearing pass.
// A stalled m_tready fills the output and sum registers, then blocks pixels with results.
module rgb_box_blur_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bb3_pkg::IN_TDATA_W-1:0]    s_tdata,   // in_red, in_green, in_blue
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bb3_pkg::OUT_TDATA_W-1:0]   m_tdata,   // out_row, out_col, out_red,
                                                          // out_green, out_blue, zero pad
    output logic                              m_tlast,   // frame_done
    input  logic                              cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]         cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EXT_W = 14;
    localparam int PW    = bb3_pkg::PIX_W;
    localparam int RW    = bb3_pkg::RGB_W;
    localparam logic [COL_W-1:0] LAST_COL_RST =
        COL_W'(((MAX_WIDTH < bb3_pkg::DIM_RESET) ? MAX_WIDTH : bb3_pkg::DIM_RESET) - 1);
    localparam logic [ROW_W-1:0] LAST_ROW_RST =
        ROW_W'(((MAX_HEIGHT < bb3_pkg::DIM_RESET) ? MAX_HEIGHT : bb3_pkg::DIM_RESET) - 1);

    logic [COL_W-1:0]    last_col_reg;
    logic [ROW_W-1:0]    last_row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic [EXT_W-1:0]    cfg_ext;
    logic [EXT_W-1:0]    w_clamp;
    logic [EXT_W-1:0]    h_clamp;
    logic [EXT_W-1:0]    w_last;
    logic [EXT_W-1:0]    h_last;
    logic                acc;
    logic                win_free;
    bb3_pkg::pos_flags_t flags;
    logic                mem_rd_en;
    logic [COL_W-1:0]    mem_rd_addr;
    logic [2*RW-1:0]     mem_rd_data;
    logic                mem_wr_en;
    logic [COL_W-1:0]    mem_wr_addr;
    logic [2*RW-1:0]     mem_wr_data;
    logic                sum_valid;
    logic                sum_ready;
    bb3_pkg::sum_item_t  sum_item;
    logic [bb3_pkg::POS_W-1:0] out_row;
    logic [bb3_pkg::POS_W-1:0] out_col;
    logic [PW-1:0]       out_red;
    logic [PW-1:0]       out_green;
    logic [PW-1:0]       out_blue;

    // dimension clamp: 0 acts as 1, anything above the maximum as the maximum
    assign cfg_ext = {{(EXT_W-bb3_pkg::CFG_W){1'b0}}, cfg_data};
    assign w_clamp = (cfg_ext == '0) ? EXT_W'(1)
                   : ((cfg_ext > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : cfg_ext);
    assign h_clamp = (cfg_ext == '0) ? EXT_W'(1)
                   : ((cfg_ext > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : cfg_ext);
    assign w_last  = w_clamp - EXT_W'(1);
    assign h_last  = h_clamp - EXT_W'(1);

    assign s_tready = win_free;
    assign acc      = s_tvalid && win_free;

    // where the incoming pixel sits in the image
    assign flags.ir_ge1   = (row_reg != '0);
    assign flags.ir_ge2   = (row_reg > ROW_W'(1));
    assign flags.ic_ge1   = (col_reg != '0);
    assign flags.ic_ge2   = (col_reg > COL_W'(1));
    assign flags.last_row = (row_reg == last_row_reg);
    assign flags.last_col = (col_reg == last_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RST;
            last_row_reg <= LAST_ROW_RST;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bb3_pkg::CFG_IMAGE_WIDTH:
                begin
                    last_col_reg <= w_last[COL_W-1:0];
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                bb3_pkg::CFG_IMAGE_HEIGHT:
                begin
                    last_row_reg <= h_last[ROW_W-1:0];
                    col_reg      <= '0;
                    row_reg      <= '0;
                end
                default:
                begin
                    last_col_reg <= last_col_reg;
                end
            endcase
        end
        else if (acc)
        begin
            if (flags.last_col)
            begin
                col_reg <= '0;
                row_reg <= flags.last_row ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    bb3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W),
        .DATA_W (2 * RW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bb3_window #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .in_pix      ({s_tdata[PW-1:0], s_tdata[2*PW-1:PW], s_tdata[3*PW-1:2*PW]}),
        .in_row      (row_reg),
        .in_col      (col_reg),
        .in_flags    (flags),
        .free        (win_free),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .sum_valid   (sum_valid),
        .sum_item    (sum_item),
        .sum_ready   (sum_ready)
    );

    bb3_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_item  (sum_item),
        .sum_ready (sum_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_done  (m_tlast)
    );

    assign m_tdata = {4'b0000, out_blue, out_green, out_red, out_col, out_row};

endmodule
